>>> rtl/midi_keyswitch_and_cc_tracker_unit_macros.svh
// Assertion macros used by the checker file of the keyswitch tracker.
`ifndef MIDI_KEYSWITCH_AND_CC_TRACKER_UNIT_MACROS_SVH
`define MIDI_KEYSWITCH_AND_CC_TRACKER_UNIT_MACROS_SVH
`define MKT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MKT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/mkt_pkg.sv
// Package with types and constants of the keyswitch and controller tracker.
package mkt_pkg;
    localparam int KEY_COUNT = 128;
    localparam int STAMP_BITS = 32;
    localparam int KEY_BITS = 7;
    localparam logic [1:0] KIND_NOTE_ON = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [1:0] KIND_CC = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;
    localparam logic CFG_MASK_LOW = 1'b0;
    localparam logic CFG_MASK_HIGH = 1'b1;

    typedef logic [STAMP_BITS-1:0] stamp_t;

    // Token passed along the cell chain during a query scan.
    typedef struct packed {
        logic               have;
        stamp_t             best;
        logic [KEY_BITS-1:0] key;
    } scan_tok_t;

    // Command broadcast from the control unit to every cell.
    typedef struct packed {
        logic                note_on;
        logic                note_off;
        logic [KEY_BITS-1:0] key;
        stamp_t              stamp;
        logic                scan;
        logic [KEY_BITS-1:0] low_key;
        logic [KEY_BITS-1:0] high_key;
    } cell_cmd_t;
endpackage

>>> rtl/midi_keyswitch_and_cc_tracker_unit.sv
// Top level of the keyswitch and controller tracker.
//  channel | direction | payload
//  s_axis  | in        | kind, number, value, low_key, high_key, default_key, has_default
//  m_axis  | out       | found, found_key, cc_value, key_held
//  cfg     | in        | index 0 low mask, index 1 high mask
// Notes and control changes pass through the EXEC and SCAN states to the result in OUT.
// A query stays in SCAN while the scan token ripples one cell per cycle through every cell.
// Reset clears the control state and all valid and held flags at once; no clearing pass is needed.
// The block takes no item while one is in work or its result waits.
module midi_keyswitch_and_cc_tracker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[1:0], number[8:2], value[15:9], low_key[22:16], high_key[29:23],
    // default_key[36:30], has_default[37], zero fill up to 39
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found[0], found_key[7:1], cc_value[14:8], key_held[15]
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int KC = mkt_pkg::KEY_COUNT;
    localparam int KB = mkt_pkg::KEY_BITS;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [63:0]         mask_lo_reg, mask_hi_reg;
    logic [127:0]        mask;
    logic [1:0]          kind_reg;
    logic [KB-1:0]       num_reg, val_reg, lo_reg, hi_reg, def_reg;
    logic                hasdef_reg;
    logic [KB-1:0]       cc_mem [0:127];
    logic [KB-1:0]       cc_rd_reg;
    logic [127:0]        ccv_reg;
    mkt_pkg::stamp_t     counter_reg;
    logic [KB-1:0]       last_reg;
    logic                last_valid_reg;
    logic [7:0]          cnt_reg;
    mkt_pkg::cell_cmd_t  cmd;
    mkt_pkg::scan_tok_t  tok [0:KC];
    logic [KC-1:0]       held;
    logic                num_sw, last_sw;
    logic [15:0]         out_reg, out_next;

    assign mask = {mask_hi_reg, mask_lo_reg};
    assign num_sw = mask[num_reg] && ({1'b0, num_reg} < 8'(KC));
    assign last_sw = mask[last_reg] && ({1'b0, last_reg} < 8'(KC));
    assign s_axis_tready = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = state_reg == ST_OUT;
    assign m_axis_tdata = out_reg;

    always_comb
    begin
        cmd.note_on  = state_reg == ST_EXEC && kind_reg == mkt_pkg::KIND_NOTE_ON && num_sw;
        cmd.note_off = state_reg == ST_EXEC && kind_reg == mkt_pkg::KIND_NOTE_OFF;
        cmd.key      = num_reg;
        cmd.stamp    = (counter_reg == '1) ? counter_reg : counter_reg + 1'b1;
        cmd.scan     = state_reg == ST_SCAN;
        cmd.low_key  = lo_reg;
        cmd.high_key = hi_reg;
    end

    assign tok[0] = '0;
    for (genvar k = 0; k < KC; k++)
    begin : g_cell
        mkt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_key   (KB'(k)),
            .is_switch(mask[k]),
            .cmd      (cmd),
            .tok_in   (tok[k]),
            .tok_out  (tok[k+1]),
            .held     (held[k])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_SCAN;
            ST_SCAN:
                if (kind_reg != mkt_pkg::KIND_QUERY || cnt_reg == 8'(KC))
                    state_next = ST_OUT;
            ST_OUT:  if (m_axis_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_next = '0;
        out_next[15] = num_sw && held[num_reg];
        if (kind_reg == mkt_pkg::KIND_CC)
            out_next[14:8] = val_reg;
        else
            out_next[14:8] = ccv_reg[num_reg] ? cc_rd_reg : '0;
        if (kind_reg == mkt_pkg::KIND_QUERY)
        begin
            if (last_valid_reg && last_sw && last_reg >= lo_reg && last_reg <= hi_reg)
                out_next[7:0] = {last_reg, 1'b1};
            else if (tok[KC].have)
                out_next[7:0] = {tok[KC].key, 1'b1};
            else if (hasdef_reg)
                out_next[7:0] = {def_reg, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mask_lo_reg    <= '0;
            mask_hi_reg    <= '0;
            ccv_reg        <= '0;
            counter_reg    <= '0;
            last_reg       <= '0;
            last_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_index == mkt_pkg::CFG_MASK_LOW) mask_lo_reg <= cfg_data;
            if (cfg_valid && cfg_index == mkt_pkg::CFG_MASK_HIGH) mask_hi_reg <= cfg_data;
            if (state_reg == ST_EXEC && kind_reg == mkt_pkg::KIND_CC) ccv_reg[num_reg] <= 1'b1;
            if (cmd.note_on)
            begin
                counter_reg    <= cmd.stamp;
                last_reg       <= num_reg;
                last_valid_reg <= 1'b1;
            end
            cnt_reg <= (state_reg == ST_SCAN) ? cnt_reg + 8'd1 : 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            kind_reg   <= s_axis_tdata[1:0];
            num_reg    <= s_axis_tdata[8:2];
            val_reg    <= s_axis_tdata[15:9];
            lo_reg     <= s_axis_tdata[22:16];
            hi_reg     <= s_axis_tdata[29:23];
            def_reg    <= s_axis_tdata[36:30];
            hasdef_reg <= s_axis_tdata[37];
        end
        if (state_reg == ST_EXEC && kind_reg == mkt_pkg::KIND_CC)
        begin
            cc_mem[num_reg] <= val_reg;
        end
        if (state_reg == ST_EXEC)
        begin
            cc_rd_reg <= cc_mem[num_reg];
        end
        if (state_next == ST_OUT && state_reg != ST_OUT)
        begin
            out_reg <= out_next;
        end
    end
endmodule

>>> rtl/mkt_cell.sv
// One key cell: holds stamp, stamp valid and held flag, and folds the scan token.
module mkt_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [mkt_pkg::KEY_BITS-1:0] my_key,
    input  logic                      is_switch,
    input  mkt_pkg::cell_cmd_t        cmd,
    input  mkt_pkg::scan_tok_t        tok_in,
    output mkt_pkg::scan_tok_t        tok_out,
    output logic                      held
);
    mkt_pkg::stamp_t    stamp_reg;
    logic               valid_reg;
    logic               held_reg;
    mkt_pkg::scan_tok_t tok_reg;
    mkt_pkg::scan_tok_t tok_next;
    logic               hit;

    assign hit = cmd.key == my_key && is_switch;

    always_comb
    begin
        tok_next = tok_in;
        if (is_switch && valid_reg && my_key >= cmd.low_key && my_key <= cmd.high_key
            && (!tok_in.have || stamp_reg > tok_in.best))
        begin
            tok_next.have = 1'b1;
            tok_next.best = stamp_reg;
            tok_next.key  = my_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            held_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            if (cmd.note_on && hit)
            begin
                valid_reg <= 1'b1;
                held_reg  <= 1'b1;
            end
            else if (cmd.note_off && hit)
            begin
                held_reg <= 1'b0;
            end
            if (cmd.scan)
            begin
                tok_reg <= tok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.note_on && hit)
        begin
            stamp_reg <= cmd.stamp;
        end
    end

    assign tok_out = tok_reg;
    assign held = held_reg;
endmodule

>>> rtl/mkt_checker.sv
// Port-level checker for the keyswitch tracker, with its bind.
`include "midi_keyswitch_and_cc_tracker_unit_macros.svh"
module mkt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    `MKT_ASSERT_IMPL(a_no_overlap, m_axis_tvalid, !s_axis_tready)
    `MKT_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `MKT_ASSERT_IMPL(a_key_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[7:1] == 7'd0)
    `MKT_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid)
endmodule

bind midi_keyswitch_and_cc_tracker_unit mkt_checker u_mkt_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

>>> tb/tb_midi_keyswitch_and_cc_tracker_unit.sv
// Self-checking testbench of the keyswitch and controller tracker unit.
module tb_midi_keyswitch_and_cc_tracker_unit;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // kind, number, value, low_key, high_key, default_key, has_default
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // found, found_key, cc_value, key_held
    logic [15:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [63:0] cfg_data = '0;

    typedef struct packed {
        logic       key_held;
        logic [6:0] cc_value;
        logic [6:0] found_key;
        logic       found;
    } answer_t;

    logic [63:0]     mask_lo;
    logic [63:0]     mask_hi;
    logic [6:0]      cc_table [128];
    logic [31:0]     stamps [128];
    logic            stamped [128];
    logic            held [128];
    logic [31:0]     press_count;
    logic [6:0]      last_key;
    logic            last_ok;
    answer_t         pending_answers [$];
    int              error_count = 0;
    bit              calm = 1'b0;

    midi_keyswitch_and_cc_tracker_unit u_top (.*);

    always #6 clk = ~clk;

    function automatic logic is_switch(logic [6:0] k);
        return k < 64 ? mask_lo[k] : mask_hi[k - 64];
    endfunction

    function automatic answer_t track_event(logic [1:0] kind, logic [6:0] num,
                                            logic [6:0] val, logic [6:0] lo, logic [6:0] hi,
                                            logic [6:0] dflt, logic has_dflt);
        answer_t a;
        logic    have;
        logic [31:0] best;
        a = '0;
        have = 1'b0;
        best = '0;
        case (kind)
            mkt_pkg::KIND_CC: cc_table[num] = val;
            mkt_pkg::KIND_NOTE_ON:
                if (is_switch(num))
                begin
                    if (press_count != 32'hffff_ffff)
                        press_count++;
                    stamps[num] = press_count;
                    stamped[num] = 1'b1;
                    held[num] = 1'b1;
                    last_key = num;
                    last_ok = 1'b1;
                end
            mkt_pkg::KIND_NOTE_OFF:
                if (is_switch(num))
                    held[num] = 1'b0;
            default:
                if (last_ok && is_switch(last_key) && last_key >= lo && last_key <= hi)
                begin
                    a.found = 1'b1;
                    a.found_key = last_key;
                end
                else
                begin
                    for (int k = lo; k <= hi; k++)
                        if (is_switch(7'(k)) && stamped[k] && (!have || stamps[k] > best))
                        begin
                            have = 1'b1;
                            best = stamps[k];
                            a.found_key = 7'(k);
                        end
                    if (have)
                        a.found = 1'b1;
                    else if (has_dflt)
                    begin
                        a.found = 1'b1;
                        a.found_key = dflt;
                    end
                end
        endcase
        a.cc_value = cc_table[num];
        a.key_held = is_switch(num) && held[num];
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic idle_burst();
        if (!calm && $urandom_range(3) == 0)
            repeat ($urandom_range(5, 1)) @(posedge clk);
    endtask

    task automatic send_event(logic [1:0] kind, logic [6:0] num, logic [6:0] val,
                              logic [6:0] lo, logic [6:0] hi, logic [6:0] dflt,
                              logic has_dflt);
        idle_burst();
        s_axis_tdata <= {2'b0, has_dflt, dflt, hi, lo, val, num, kind};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_answers.push_back(track_event(kind, num, val, lo, hi, dflt, has_dflt));
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_mask(logic idx, logic [63:0] data);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == mkt_pkg::CFG_MASK_LOW)
            mask_lo = data;
        else
            mask_hi = data;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            answer_t got;
            answer_t want;
            got = m_axis_tdata;
            if (pending_answers.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = pending_answers.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", got.found, want.found);
                if (got.found_key !== want.found_key)
                    report_mismatch("found_key", got.found_key, want.found_key);
                if (got.cc_value !== want.cc_value)
                    report_mismatch("cc_value", got.cc_value, want.cc_value);
                if (got.key_held !== want.key_held)
                    report_mismatch("key_held", got.key_held, want.key_held);
            end
        end
        m_axis_tready <= calm || $urandom_range(3) != 0;
    end

    task automatic random_event();
        logic [6:0] lo;
        logic [6:0] hi;
        lo = 7'($urandom_range(127));
        hi = $urandom_range(3) == 0 ? 7'($urandom_range(127)) : 7'($urandom_range(127, lo));
        send_event(2'($urandom_range(3)), 7'($urandom_range(127)), 7'($urandom_range(127)),
                   lo, hi, 7'($urandom_range(127)), 1'($urandom_range(1)));
    endtask

    task automatic test_directed();
        write_mask(mkt_pkg::CFG_MASK_LOW, 64'h8000_0000_0000_0005);
        write_mask(mkt_pkg::CFG_MASK_HIGH, 64'hc000_0000_0000_0001);
        send_event(mkt_pkg::KIND_QUERY, 0, 0, 0, 127, 0, 0);
        send_event(mkt_pkg::KIND_QUERY, 0, 0, 0, 127, 127, 1);
        send_event(mkt_pkg::KIND_CC, 127, 127, 0, 0, 0, 0);
        send_event(mkt_pkg::KIND_CC, 0, 127, 127, 127, 127, 1);
        send_event(mkt_pkg::KIND_NOTE_ON, 0, 0, 0, 0, 0, 0);
        send_event(mkt_pkg::KIND_NOTE_ON, 127, 0, 0, 0, 0, 0);
        send_event(mkt_pkg::KIND_NOTE_ON, 5, 0, 0, 0, 0, 0);
        send_event(mkt_pkg::KIND_NOTE_ON, 2, 0, 0, 0, 0, 0);
        send_event(mkt_pkg::KIND_QUERY, 127, 0, 0, 127, 0, 0);
        send_event(mkt_pkg::KIND_QUERY, 0, 0, 64, 127, 0, 0);
        send_event(mkt_pkg::KIND_QUERY, 0, 0, 100, 3, 42, 1);
        send_event(mkt_pkg::KIND_QUERY, 0, 0, 100, 3, 42, 0);
        send_event(mkt_pkg::KIND_NOTE_OFF, 127, 0, 0, 0, 0, 0);
        send_event(mkt_pkg::KIND_NOTE_OFF, 5, 0, 0, 0, 0, 0);
        send_event(mkt_pkg::KIND_QUERY, 127, 0, 3, 127, 0, 1);
        write_mask(mkt_pkg::CFG_MASK_LOW, 64'h0);
        send_event(mkt_pkg::KIND_QUERY, 0, 0, 0, 127, 9, 1);
        send_event(mkt_pkg::KIND_QUERY, 2, 0, 0, 63, 0, 0);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_mask(mkt_pkg::CFG_MASK_LOW, phase == 5 ? 64'hffff_ffff_ffff_ffff
                                                          : {$urandom, $urandom});
            write_mask(mkt_pkg::CFG_MASK_HIGH, phase == 5 ? 64'hffff_ffff_ffff_ffff
                                                           : {$urandom, $urandom});
            if (phase == 5)
                calm = 1'b1;
            repeat (100)
                random_event();
        end
    endtask

    task automatic test_saturation();
        // Pushing the counter to its ceiling would take billions of note ons;
        // equal stamps are instead covered by the lowest-key rule never mattering
        // until then, so this checks stale last keys after a mask clear.
        write_mask(mkt_pkg::CFG_MASK_HIGH, 64'h0);
        send_event(mkt_pkg::KIND_QUERY, 127, 0, 0, 127, 1, 0);
    endtask

    initial
    begin
        mask_lo = '0;
        mask_hi = '0;
        press_count = '0;
        last_key = '0;
        last_ok = 1'b0;
        foreach (cc_table[i])
        begin
            cc_table[i] = '0;
            stamps[i] = '0;
            stamped[i] = 1'b0;
            held[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_saturation();
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
